// ----- rtl/core/ffdc_pkg.sv -----
// ----------------------------------------------------------------------------
// ffdc_pkg
// shared constants and types of the fixed-length frame deframer
// ----------------------------------------------------------------------------
package ffdc_pkg;

  localparam int unsigned FRAME_LEN = 85;
  localparam int unsigned SKIP_W    = $clog2(FRAME_LEN);

  localparam logic [7:0]        SOF_BYTE  = 8'hFE;
  localparam logic [7:0]        EOF_BYTE  = 8'hFF;
  localparam logic [SKIP_W-1:0] SKIP_INIT = SKIP_W'(FRAME_LEN - 1);

  typedef enum logic [1:0] {
    STATUS_NONE = 2'd0,
    STATUS_GOOD = 2'd1,
    STATUS_BAD  = 2'd2
  } frame_status_e;

  // taps of the window that one accepted byte needs
  typedef struct packed {
    logic [7:0] head_byte;  // byte that becomes the oldest one
    logic [7:0] tail_byte;  // byte that becomes the checksum byte
    logic [7:0] sum_next;   // running sum after the shift
  } win_tap_t;

endpackage

// ----- rtl/core/ffdc_byte_if.sv -----
// ----------------------------------------------------------------------------
// ffdc_byte_if
// request channel carrying one received serial byte
// ----------------------------------------------------------------------------
interface ffdc_byte_if;

  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);

endinterface

// ----- rtl/core/ffdc_status_if.sv -----
// ----------------------------------------------------------------------------
// ffdc_status_if
// request channel carrying the frame status and both checksums
// ----------------------------------------------------------------------------
interface ffdc_status_if;

  logic       valid;
  logic       ready;
  logic [1:0] frame_status;
  logic [7:0] computed_sum;
  logic [7:0] carried_sum;

  modport source (output valid, output frame_status, output computed_sum,
                  output carried_sum, input ready);
  modport sink (input valid, input frame_status, input computed_sum,
                input carried_sum, output ready);

endinterface

// ----- rtl/core/ffdc_window.sv -----
// ----------------------------------------------------------------------------
// ffdc_window
// byte shift window with running checksum over the frame body
// ----------------------------------------------------------------------------
module ffdc_window import ffdc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic [7:0] byte_i,
  output win_tap_t   tap_o
);

  logic [7:0] win_q [FRAME_LEN];
  logic [7:0] sum_q;
  logic [7:0] sum_d;

  // body positions 1..L-3 move in from old positions 2..L-2
  assign sum_d = sum_q - win_q[1] + win_q[FRAME_LEN-2];

  assign tap_o.head_byte = win_q[1];
  assign tap_o.tail_byte = win_q[FRAME_LEN-1];
  assign tap_o.sum_next  = sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FRAME_LEN; i++) begin
        win_q[i] <= 8'h00;
      end
      sum_q <= 8'h00;
    end else if (shift_i) begin
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[FRAME_LEN-1] <= byte_i;
      sum_q              <= sum_d;
    end
  end

endmodule

// ----- rtl/core/fixed_frame_deframer_checksum.sv -----
// ----------------------------------------------------------------------------
// fixed_frame_deframer_checksum
// fixed-length frame sync on a byte stream with 8-bit additive checksum
// a result is registered and valid in the cycle after its byte is accepted
// throughput: one byte per cycle while the status sink is ready, set by the single-step window shift and sum
// the output register frees its slot in the same cycle it is taken
// reset clears the window, running sum, skip count and output valid
// ----------------------------------------------------------------------------
module fixed_frame_deframer_checksum import ffdc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ffdc_byte_if.sink            rx_i,
  ffdc_status_if.source        status_o
);

  win_tap_t          tap;
  logic              accept;
  logic              match;
  logic [SKIP_W-1:0] skip_q;
  logic [SKIP_W-1:0] skip_d;
  logic              out_valid_q;
  frame_status_e     status_q;
  frame_status_e     status_d;
  logic [7:0]        calc_q;
  logic [7:0]        calc_d;
  logic [7:0]        carr_q;
  logic [7:0]        carr_d;

  assign rx_i.ready = !out_valid_q || status_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;

  ffdc_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .shift_i(accept),
    .byte_i (rx_i.rx_byte),
    .tap_o  (tap)
  );

  assign match = (skip_q == '0) && (tap.head_byte == SOF_BYTE) &&
                 (rx_i.rx_byte == EOF_BYTE);

  always_comb begin
    skip_d   = skip_q;
    status_d = STATUS_NONE;
    calc_d   = 8'h00;
    carr_d   = 8'h00;
    if (skip_q != '0) begin
      skip_d = skip_q - SKIP_W'(1);
    end else if (match) begin
      skip_d   = SKIP_INIT;
      calc_d   = tap.sum_next;
      carr_d   = tap.tail_byte;
      status_d = (tap.sum_next == tap.tail_byte) ? STATUS_GOOD : STATUS_BAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        skip_q      <= skip_d;
        out_valid_q <= 1'b1;
      end else if (status_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      calc_q   <= calc_d;
      carr_q   <= carr_d;
    end
  end

  assign status_o.valid        = out_valid_q;
  assign status_o.frame_status = status_q;
  assign status_o.computed_sum = calc_q;
  assign status_o.carried_sum  = carr_q;

  // a match reloads the skip counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && match |=> skip_q == SKIP_INIT)
    else $error("skip counter not reloaded after match");

  // no match can be reported while matching is suppressed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && skip_q != '0 |=> status_o.frame_status == STATUS_NONE)
    else $error("frame reported during skip");

  // a good frame carries equal checksums
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.valid && status_o.frame_status == STATUS_GOOD |->
      status_o.computed_sum == status_o.carried_sum)
    else $error("good frame with unequal checksums");

  // no frame end gives zero checksums
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.valid && status_o.frame_status == STATUS_NONE |->
      status_o.computed_sum == 8'h00 && status_o.carried_sum == 8'h00)
    else $error("checksums nonzero without frame");

  // an empty output slot never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> rx_i.ready)
    else $error("input stalled with empty output register");

endmodule
